// ===== design/tekd_pkg.sv =====
// ----------------------------------------------------------------------------
// tekd_pkg: shared types and constants for the terminal escape key decoder
// Byte codes, escape phase codes and the bundles passed between modules.
// ----------------------------------------------------------------------------
package tekd_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned PhaseW = 3;
	localparam int unsigned CfgIdxW = 1;

	// Escape phase codes.
	localparam logic [PhaseW-1:0] PH_PLAIN   = 3'd0;
	localparam logic [PhaseW-1:0] PH_ESC     = 3'd1;
	localparam logic [PhaseW-1:0] PH_BRACKET = 3'd2;
	localparam logic [PhaseW-1:0] PH_DIGIT1  = 3'd3;
	localparam logic [PhaseW-1:0] PH_DIGIT2  = 3'd4;
	localparam logic [PhaseW-1:0] PH_CR      = 3'd5;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] CFG_END_KEY  = 1'd0;
	localparam logic [CfgIdxW-1:0] CFG_HOME_KEY = 1'd1;

	localparam logic [ByteW-1:0] END_KEY_RESET  = 8'd12;
	localparam logic [ByteW-1:0] HOME_KEY_RESET = 8'd11;

	// Byte codes.
	localparam logic [ByteW-1:0] BYTE_NUL   = 8'd0;
	localparam logic [ByteW-1:0] BYTE_BS    = 8'd8;
	localparam logic [ByteW-1:0] BYTE_LF    = 8'd10;
	localparam logic [ByteW-1:0] BYTE_CR    = 8'd13;
	localparam logic [ByteW-1:0] BYTE_ESC   = 8'd27;
	localparam logic [ByteW-1:0] BYTE_DEL   = 8'd127;
	localparam logic [ByteW-1:0] BYTE_LBRK  = 8'h5B;
	localparam logic [ByteW-1:0] BYTE_SS3   = 8'h4F;
	localparam logic [ByteW-1:0] BYTE_TILDE = 8'h7E;
	localparam logic [ByteW-1:0] BYTE_A     = 8'h41;
	localparam logic [ByteW-1:0] BYTE_D     = 8'h44;
	localparam logic [ByteW-1:0] BYTE_F     = 8'h46;
	localparam logic [ByteW-1:0] BYTE_H     = 8'h48;
	localparam logic [ByteW-1:0] BYTE_0     = 8'h30;
	localparam logic [ByteW-1:0] BYTE_1     = 8'h31;
	localparam logic [ByteW-1:0] BYTE_6     = 8'h36;
	localparam logic [ByteW-1:0] BYTE_9     = 8'h39;

	typedef struct packed {
		logic [PhaseW-1:0] phase;
		logic [ByteW-1:0]  digits;
	} tekd_state_t;

	typedef struct packed {
		logic [ByteW-1:0] end_code;
		logic [ByteW-1:0] home_code;
	} tekd_cfg_t;

	typedef struct packed {
		logic             is_extra;
		logic [ByteW-1:0] key_code;
	} tekd_key_t;

endpackage

// ===== design/tekd_rx_if.sv =====
// ----------------------------------------------------------------------------
// tekd_rx_if: received byte channel
// Valid/ready channel carrying one terminal byte per item.
// ----------------------------------------------------------------------------
interface tekd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== design/tekd_key_if.sv =====
// ----------------------------------------------------------------------------
// tekd_key_if: decoded key channel
// Valid/ready channel carrying one decoded key per item.
// ----------------------------------------------------------------------------
interface tekd_key_if;
	logic       valid;
	logic       ready;
	logic       is_extra;
	logic [7:0] key_code;

	modport source (output valid, output is_extra, output key_code, input ready);
	modport sink (input valid, input is_extra, input key_code, output ready);
endinterface

// ===== design/tekd_cfg.sv =====
// ----------------------------------------------------------------------------
// tekd_cfg: configuration registers
// Holds the END and HOME key codes, written through a plain write port.
// ----------------------------------------------------------------------------
module tekd_cfg
	import tekd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               we,
	input  logic [CfgIdxW-1:0] index,
	input  logic [ByteW-1:0]   data,
	output tekd_cfg_t          cfg
);

	logic [ByteW-1:0] end_code_q;
	logic [ByteW-1:0] home_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_code_q  <= END_KEY_RESET;
			home_code_q <= HOME_KEY_RESET;
		end else if (we) begin
			case (index)
				CFG_END_KEY:  end_code_q  <= data;
				CFG_HOME_KEY: home_code_q <= data;
				default: begin
				end
			endcase
		end
	end

	assign cfg.end_code  = end_code_q;
	assign cfg.home_code = home_code_q;

endmodule

// ===== design/tekd_decode.sv =====
// ----------------------------------------------------------------------------
// tekd_decode: escape sequence decode logic
// Maps one byte and the current escape state to a key and the next state.
// ----------------------------------------------------------------------------
module tekd_decode
	import tekd_pkg::*;
(
	input  logic [ByteW-1:0] rx_byte,
	input  tekd_state_t      cur,
	input  tekd_cfg_t        cfg,
	output tekd_state_t      nxt,
	output tekd_key_t        key
);

	logic [ByteW-1:0] digit_val;

	assign digit_val = rx_byte - BYTE_0;

	always_comb begin
		nxt          = cur;
		key.is_extra = 1'b0;
		key.key_code = BYTE_NUL;
		if (rx_byte == BYTE_NUL) begin
			// Empty item: nothing changes.
		end else if (rx_byte == BYTE_DEL) begin
			key.key_code = BYTE_BS;
		end else if (rx_byte == BYTE_ESC) begin
			nxt.phase = PH_ESC;
		end else begin
			case (cur.phase)
				PH_BRACKET: begin
					if (rx_byte inside {[BYTE_A:BYTE_D]}) begin
						nxt.phase    = PH_PLAIN;
						key.is_extra = 1'b1;
						key.key_code = rx_byte - BYTE_A + 8'd1;
					end else if (rx_byte == BYTE_F) begin
						nxt.phase    = PH_PLAIN;
						key.is_extra = 1'b1;
						key.key_code = cfg.end_code;
					end else if (rx_byte == BYTE_H) begin
						nxt.phase    = PH_PLAIN;
						key.is_extra = 1'b1;
						key.key_code = cfg.home_code;
					end else if (rx_byte inside {[BYTE_1:BYTE_6]}) begin
						nxt.phase  = PH_DIGIT1;
						nxt.digits = digit_val;
					end else begin
						// Unknown byte passes through; the bracket phase is kept.
						key.key_code = rx_byte;
					end
				end
				PH_DIGIT1: begin
					if (rx_byte == BYTE_TILDE) begin
						nxt.phase    = PH_PLAIN;
						key.is_extra = 1'b1;
						key.key_code = cur.digits + 8'd4;
					end else if (rx_byte inside {[BYTE_0:BYTE_9]}) begin
						nxt.phase  = PH_DIGIT2;
						nxt.digits = {cur.digits[3:0], digit_val[3:0]};
					end else begin
						nxt.phase = PH_PLAIN;
					end
				end
				PH_DIGIT2: begin
					nxt.phase = PH_PLAIN;
					if (rx_byte == BYTE_TILDE) begin
						key.is_extra = 1'b1;
						key.key_code = cur.digits;
					end
				end
				default: begin
					// Plain, after ESC, after CR and the unused codes.
					if (cur.phase == PH_ESC && (rx_byte == BYTE_LBRK || rx_byte == BYTE_SS3)) begin
						nxt.phase = PH_BRACKET;
					end else if (rx_byte == BYTE_CR) begin
						nxt.phase    = PH_CR;
						key.key_code = BYTE_LF;
					end else if (rx_byte == BYTE_LF && cur.phase == PH_CR) begin
						nxt.phase = PH_PLAIN;
					end else begin
						nxt.phase    = PH_PLAIN;
						key.key_code = rx_byte;
					end
				end
			endcase
		end
	end

endmodule

// ===== design/terminal_escape_key_decoder.sv =====
// ----------------------------------------------------------------------------
// terminal_escape_key_decoder: terminal byte to key code decoder
// Turns a stream of terminal bytes into plain characters and special keys.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Payload                 | Handshake
//   --------+-----------+-------------------------+------------------------
//   rx      | in        | rx_byte[7:0]            | valid && ready
//   key     | out       | is_extra, key_code[7:0] | valid && ready
//   cfg     | in        | cfg_index, cfg_data     | cfg_we (no back-pressure)
//
// Every item gives exactly one key item, passing through the input register
// and then the result register. One item is accepted per cycle while the key
// channel does not stall; the single decode stage between the input register
// and the result register also updates the escape state. A stall on the key
// channel propagates back to rx ready in the same cycle, so no item is lost.
// Reset returns the escape state to plain, clears both valid flags and loads
// the END and HOME codes with their defaults.
//
module terminal_escape_key_decoder
	import tekd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	tekd_rx_if.sink            rx,
	tekd_key_if.source         key,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [ByteW-1:0]   cfg_data
);

	// Input register stage.
	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;

	// Result register.
	logic             out_valid_q;
	tekd_key_t        out_key_q;

	// Escape state, updated when the stage-1 item moves into the result register.
	tekd_state_t      state_q;

	tekd_cfg_t        cfg;
	tekd_state_t      state_nxt;
	tekd_key_t        key_nxt;
	logic             out_load;
	logic             s1_load;

	// The result register can take a new item when it is empty or being drained.
	assign out_load = !out_valid_q || key.ready;
	assign s1_load  = !valid_s1 || out_load;
	assign rx.ready = s1_load;

	tekd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	tekd_decode u_decode (
		.rx_byte (byte_s1),
		.cur     (state_q),
		.cfg     (cfg),
		.nxt     (state_nxt),
		.key     (key_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			state_q     <= '{phase: PH_PLAIN, digits: '0};
		end else if (out_load) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && valid_s1) begin
			out_key_q <= key_nxt;
		end
	end

	assign key.valid    = out_valid_q;
	assign key.is_extra = out_key_q.is_extra;
	assign key.key_code = out_key_q.key_code;

`ifndef SYNTHESIS
	// Collected digits are never zero while a digit sequence is open.
	a_digits_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_DIGIT1 || state_q.phase == PH_DIGIT2) |-> state_q.digits != '0)
		else $error("digit sequence open with zero digits");

	// After one digit only the values one to six can be held.
	a_digit1_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_DIGIT1 |-> (state_q.digits >= 8'd1 && state_q.digits <= 8'd6))
		else $error("single digit out of range");

	// An empty byte leaves the escape state untouched.
	a_nul_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_load && byte_s1 == BYTE_NUL) |=> $stable(state_q))
		else $error("empty byte changed the escape state");

	// A stage-1 item moving on always shows up as a result.
	a_item_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_load) |=> out_valid_q)
		else $error("item lost between stages");
`endif

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the terminal escape key decoder
// Feeds terminal bytes through the rx channel and checks every decoded key
// against a cycle-free decoder kept in the bench. Several END and HOME code
// settings, randomized idling on both channels and a long key-side stall are
// covered along the way.
// ----------------------------------------------------------------------------
module tb_top;
	import tekd_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 11;
	// No item and no key moving for this many cycles means the block is hung.
	localparam int STALL_LIMIT  = 2000;
	// Length of the forced key-side stall, long enough to back the block up.
	localparam int HOLDOFF_LEN  = 150;
	// Random bytes queued per configuration setting.
	localparam int PHASE_BYTES  = 255;
	localparam int NUM_PHASES   = 6;
	// Only the first few mismatches are printed; all of them are counted.
	localparam int MAX_REPORTS  = 40;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CfgIdxW-1:0] cfg_index;
	logic [ByteW-1:0] cfg_data;

	tekd_rx_if  rx_ch ();
	tekd_key_if key_ch ();

	terminal_escape_key_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_ch),
		.key       (key_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Bytes waiting to be offered, and the keys the decoder must still deliver.
	logic [ByteW-1:0] pending_bytes[$];
	tekd_key_t        expected_keys[$];

	// Decoder model: escape phase, collected digits and the END/HOME codes.
	tekd_state_t seq_state;
	tekd_cfg_t   key_cfg;

	int  bytes_queued;
	int  bytes_in_flight;
	int  items_accepted;
	int  keys_checked;
	int  extra_keys_seen;
	int  settings_used;
	int  fail_count;
	int  stall_cycles;
	bit  rx_taken;

	// Idle percentages of the two sides; set by the sequencer at a rising edge.
	int  sender_idle_pct;
	int  receiver_idle_pct;

	// A forced stall is requested by bumping holdoff_req; the receiver process
	// notices the change and counts the stall down on its own.
	int  holdoff_req;
	int  holdoff_ack;
	int  holdoff_left;

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Decode one accepted byte into the key the block must produce, updating
	// the escape phase and the digit register the same way the block does.
	function automatic tekd_key_t decode_byte(logic [ByteW-1:0] b);
		tekd_key_t k;
		logic      as_plain;
		k.is_extra = 1'b0;
		k.key_code = BYTE_NUL;
		as_plain   = 1'b0;
		if (b == BYTE_NUL) begin
			// No byte arrived: nothing to deliver and the state is untouched.
		end else if (b == BYTE_DEL) begin
			// DEL is backspace in every phase and leaves the phase alone.
			k.key_code = BYTE_BS;
		end else if (b == BYTE_ESC) begin
			// ESC restarts a sequence from any phase.
			seq_state.phase = PH_ESC;
		end else begin
			case (seq_state.phase)
				PH_ESC: begin
					if (b == BYTE_LBRK || b == BYTE_SS3)
						seq_state.phase = PH_BRACKET;
					else
						as_plain = 1'b1;
				end
				PH_BRACKET: begin
					if (b >= BYTE_A && b <= BYTE_D) begin
						seq_state.phase = PH_PLAIN;
						k.is_extra = 1'b1;
						k.key_code = b - BYTE_A + 8'd1;
					end else if (b == BYTE_F) begin
						seq_state.phase = PH_PLAIN;
						k.is_extra = 1'b1;
						k.key_code = key_cfg.end_code;
					end else if (b == BYTE_H) begin
						seq_state.phase = PH_PLAIN;
						k.is_extra = 1'b1;
						k.key_code = key_cfg.home_code;
					end else if (b >= BYTE_1 && b <= BYTE_6) begin
						seq_state.phase  = PH_DIGIT1;
						seq_state.digits = b - BYTE_0;
					end else begin
						// Unknown byte: passed through, still after the bracket.
						k.key_code = b;
					end
				end
				PH_DIGIT1: begin
					if (b == BYTE_TILDE) begin
						seq_state.phase = PH_PLAIN;
						k.is_extra = 1'b1;
						k.key_code = seq_state.digits + 8'd4;
					end else if (b >= BYTE_0 && b <= BYTE_9) begin
						// Second digit goes into the low nibble; the top nibble drops out.
						seq_state.digits = {seq_state.digits[3:0], 4'(b - BYTE_0)};
						seq_state.phase  = PH_DIGIT2;
					end else begin
						seq_state.phase = PH_PLAIN;
					end
				end
				PH_DIGIT2: begin
					seq_state.phase = PH_PLAIN;
					if (b == BYTE_TILDE) begin
						k.is_extra = 1'b1;
						k.key_code = seq_state.digits;
					end
				end
				default: as_plain = 1'b1;
			endcase
		end
		if (as_plain) begin
			if (b == BYTE_CR) begin
				seq_state.phase = PH_CR;
				k.key_code = BYTE_LF;
			end else if (b == BYTE_LF && seq_state.phase == PH_CR) begin
				// LF right after CR is swallowed.
				seq_state.phase = PH_PLAIN;
			end else begin
				seq_state.phase = PH_PLAIN;
				k.key_code = b;
			end
		end
		return k;
	endfunction

	task automatic report_mismatch(input string what);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("tb: mismatch at %0t: %s", $realtime, what);
	endtask

	// Sender side. A new byte is put up at the falling edge when the channel
	// is free or the previous item was taken at the last rising edge.
	always @(negedge clk) begin : rx_driver
		bit offer;
		if (arst_n) begin
			if (!rx_ch.valid || rx_taken) begin
				offer = pending_bytes.size() != 0 &&
					$urandom_range(0, 99) >= sender_idle_pct;
				if (offer) begin
					rx_ch.valid   <= 1'b1;
					rx_ch.rx_byte <= pending_bytes.pop_front();
				end else begin
					rx_ch.valid   <= 1'b0;
					rx_ch.rx_byte <= 8'($urandom_range(0, 255));
				end
			end
		end
	end

	// Receiver side: random stalls, or a counted hold-off when one is asked for.
	always @(negedge clk) begin : key_receiver
		if (arst_n) begin
			if (holdoff_req != holdoff_ack) begin
				holdoff_ack  = holdoff_req;
				holdoff_left = HOLDOFF_LEN;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				key_ch.ready <= 1'b0;
			end else begin
				key_ch.ready <= $urandom_range(0, 99) >= receiver_idle_pct;
			end
		end
	end

	// Monitor: everything is sampled at the rising edge. Register writes and
	// accepted bytes feed the decoder model; every key leaving the block is
	// compared field by field with the oldest expected key.
	always @(posedge clk) begin : key_monitor
		tekd_key_t want;
		bit        key_taken;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_index == CFG_END_KEY)
					key_cfg.end_code = cfg_data;
				else if (cfg_index == CFG_HOME_KEY)
					key_cfg.home_code = cfg_data;
			end
			rx_taken  = rx_ch.valid && rx_ch.ready;
			key_taken = key_ch.valid && key_ch.ready;
			if (rx_taken) begin
				expected_keys.push_back(decode_byte(rx_ch.rx_byte));
				bytes_in_flight--;
				items_accepted++;
			end
			if (key_taken) begin
				if (expected_keys.size() == 0) begin
					report_mismatch($sformatf("key (%0b, %0h) with nothing expected",
						key_ch.is_extra, key_ch.key_code));
				end else begin
					want = expected_keys.pop_front();
					keys_checked++;
					if (want.is_extra)
						extra_keys_seen++;
					if (key_ch.is_extra !== want.is_extra)
						report_mismatch($sformatf("is_extra %0b, expected %0b",
							key_ch.is_extra, want.is_extra));
					if (key_ch.key_code !== want.key_code)
						report_mismatch($sformatf("key_code %0h, expected %0h",
							key_ch.key_code, want.key_code));
				end
			end
			stall_cycles = (rx_taken || key_taken) ? 0 : stall_cycles + 1;
		end
	end

	// Watchdog: a run in which nothing moves for too long has failed.
	initial begin : watchdog
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("tb: failure");
		$finish;
	end

	// Called only at a falling edge, so it never races the monitor's count.
	task automatic queue_byte(input logic [ByteW-1:0] b);
		pending_bytes.push_back(b);
		bytes_queued++;
		bytes_in_flight++;
	endtask

	// One random chunk of terminal traffic. Most chunks are complete escape
	// sequences with random content so the deeper phases get exercised; the
	// rest are CR/LF pairs, broken sequences and raw noise.
	task automatic queue_key_sequence();
		int kind;
		int n;
		kind = $urandom_range(0, 99);
		if (kind < 60) begin
			queue_byte(BYTE_ESC);
			queue_byte($urandom_range(0, 1) ? BYTE_LBRK : BYTE_SS3);
			// Now and then a NUL or DEL lands inside the sequence; neither breaks it.
			if ($urandom_range(0, 9) == 0)
				queue_byte($urandom_range(0, 1) ? BYTE_DEL : BYTE_NUL);
			case ($urandom_range(0, 4))
				0: queue_byte(BYTE_A + 8'($urandom_range(0, 3)));
				1: queue_byte(BYTE_F);
				2: queue_byte(BYTE_H);
				3: begin
					queue_byte(BYTE_1 + 8'($urandom_range(0, 5)));
					queue_byte(BYTE_TILDE);
				end
				default: begin
					queue_byte(BYTE_1 + 8'($urandom_range(0, 5)));
					queue_byte(BYTE_0 + 8'($urandom_range(0, 9)));
					queue_byte(BYTE_TILDE);
				end
			endcase
		end else if (kind < 72) begin
			queue_byte(BYTE_CR);
			if ($urandom_range(0, 9) < 7)
				queue_byte(BYTE_LF);
		end else if (kind < 84) begin
			queue_byte(BYTE_ESC);
			queue_byte(BYTE_LBRK);
			case ($urandom_range(0, 3))
				0: begin
					queue_byte(BYTE_1 + 8'($urandom_range(0, 5)));
					queue_byte(8'($urandom_range(1, 255)));
				end
				1: begin
					queue_byte(BYTE_1 + 8'($urandom_range(0, 5)));
					queue_byte(BYTE_0 + 8'($urandom_range(0, 9)));
					queue_byte(8'($urandom_range(1, 255)));
				end
				2: begin
					n = $urandom_range(1, 3);
					repeat (n) queue_byte(8'($urandom_range(0, 255)));
				end
				default: queue_byte(BYTE_ESC);
			endcase
		end else begin
			n = $urandom_range(1, 3);
			repeat (n) queue_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// Waits at falling edges until every queued item has been accepted and
	// every expected key has arrived, then lets the pipeline settle.
	task automatic wait_until_drained();
		while (bytes_in_flight != 0 || expected_keys.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_register(input logic [CfgIdxW-1:0] idx,
			input logic [ByteW-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_idling(input int sender_pct, input int receiver_pct);
		@(posedge clk);
		sender_idle_pct   = sender_pct;
		receiver_idle_pct = receiver_pct;
	endtask

	// Sequencer: directed bytes first, then phases of random traffic, each
	// under its own END/HOME setting. Between phases the sender stops until
	// every expected key is out, so the register writes land on an idle block.
	initial begin : sequencer
		logic [ByteW-1:0] directed[$];
		int               start_count;
		clk               = 1'b0;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = CFG_END_KEY;
		cfg_data          = '0;
		rx_ch.valid       = 1'b0;
		rx_ch.rx_byte     = '0;
		key_ch.ready      = 1'b0;
		rx_taken          = 1'b0;
		fail_count        = 0;
		stall_cycles      = 0;
		bytes_queued      = 0;
		bytes_in_flight   = 0;
		items_accepted    = 0;
		keys_checked      = 0;
		extra_keys_seen   = 0;
		settings_used     = 1;
		holdoff_req       = 0;
		holdoff_ack       = 0;
		holdoff_left      = 0;
		sender_idle_pct   = 24;
		receiver_idle_pct = 47;
		seq_state.phase   = PH_PLAIN;
		seq_state.digits  = '0;
		key_cfg.end_code  = END_KEY_RESET;
		key_cfg.home_code = HOME_KEY_RESET;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, under the reset END/HOME codes: NUL, an all-ones byte,
		// DEL, an unknown byte held after the bracket followed by a cursor key,
		// a two-digit key through ESC O, a plain byte right after ESC with the
		// CR/LF swallow, a single-digit key, a two-digit sequence dropped by a
		// wrong final byte, and HOME.
		directed = '{BYTE_NUL, 8'hFF, BYTE_DEL,
			BYTE_ESC, BYTE_LBRK, 8'h5A, BYTE_A,
			BYTE_ESC, BYTE_SS3, BYTE_6, BYTE_9, BYTE_TILDE,
			BYTE_ESC, BYTE_CR, BYTE_LF,
			BYTE_ESC, BYTE_LBRK, BYTE_1, BYTE_TILDE,
			BYTE_ESC, BYTE_LBRK, 8'h32, 8'h35, 8'h71,
			BYTE_ESC, BYTE_LBRK, BYTE_H};
		foreach (directed[i])
			queue_byte(directed[i]);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase > 0) begin
				wait_until_drained();
				settings_used++;
				case (phase)
					1: begin
						write_register(CFG_END_KEY, 8'h00);
						write_register(CFG_HOME_KEY, 8'hFF);
					end
					2: begin
						write_register(CFG_END_KEY, 8'hFF);
						write_register(CFG_HOME_KEY, 8'h00);
					end
					NUM_PHASES - 1: begin
						write_register(CFG_END_KEY, END_KEY_RESET);
						write_register(CFG_HOME_KEY, HOME_KEY_RESET);
					end
					default: begin
						write_register(CFG_END_KEY, 8'($urandom_range(0, 255)));
						write_register(CFG_HOME_KEY, 8'($urandom_range(0, 255)));
					end
				endcase
			end
			// Idling: the sender idles more lightly first, then the receiver
			// does, and the last phases run with no idling at all.
			if (phase < 2)
				set_idling(24, 47);
			else if (phase < 4)
				set_idling(47, 24);
			else
				set_idling(0, 0);
			@(negedge clk);
			start_count = bytes_queued;
			while (bytes_queued - start_count < PHASE_BYTES)
				queue_key_sequence();
			// In the last phase the receiver holds off for a long stretch while
			// the sender keeps offering, so the block fills and stalls rx.
			if (phase == NUM_PHASES - 1) begin
				@(posedge clk);
				holdoff_req++;
			end
		end

		wait_until_drained();
		repeat (8) @(negedge clk);

		$display("tb: %0d bytes accepted, %0d keys checked (%0d special keys)",
			items_accepted, keys_checked, extra_keys_seen);
		$display("tb: %0d END/HOME settings, %0d mismatches",
			settings_used, fail_count);
		if (fail_count == 0 && expected_keys.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
